// ----- hw/rtl/battery_reply_frame_receiver_unit_defines.svh -----
`ifndef BATTERY_REPLY_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define BATTERY_REPLY_FRAME_RECEIVER_UNIT_DEFINES_SVH

// Condition that holds at every clock edge outside reset.
`define BRFR_ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("brfr: invariant broken");

// Consequence required in the same cycle as the antecedent.
`define BRFR_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("brfr: same-cycle check failed");

// Consequence required in the cycle after the antecedent.
`define BRFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("brfr: next-cycle check failed");

`endif

// ----- hw/rtl/brfr_pkg.sv -----
package brfr_pkg;

  localparam int FRAME_LENGTH  = 13;
  localparam int PAYLOAD_COUNT = 8;
  localparam int QUEUE_DEPTH   = 2;

  localparam int POS_W = 4;
  localparam logic [POS_W-1:0] POS_HEADER        = 4'd0;
  localparam logic [POS_W-1:0] POS_ADDRESS       = 4'd1;
  localparam logic [POS_W-1:0] POS_PAYLOAD_FIRST = 4'd4;
  localparam logic [POS_W-1:0] POS_LAST          = POS_W'(FRAME_LENGTH - 1);

  localparam logic ACTION_BYTE       = 1'b0;
  localparam logic ACTION_LINE_ERROR = 1'b1;

  localparam logic STATUS_GOOD = 1'b0;
  localparam logic STATUS_BAD  = 1'b1;

  localparam logic SLOT_FIRST  = 1'b0;
  localparam logic SLOT_SECOND = 1'b1;

  localparam logic [1:0] REG_HEADER      = 2'd0;
  localparam logic [1:0] REG_FIRST_ADDR  = 2'd1;
  localparam logic [1:0] REG_SECOND_ADDR = 2'd2;

  localparam logic [7:0] HEADER_RESET      = 8'hA5;
  localparam logic [7:0] FIRST_ADDR_RESET  = 8'h01;
  localparam logic [7:0] SECOND_ADDR_RESET = 8'h02;

  typedef struct packed {
    logic [7:0] header_byte;
    logic [7:0] first_device_address;
    logic [7:0] second_device_address;
  } cfg_t;

  // One finished frame: status, slot and bytes 4..11 with byte 4 on top.
  typedef struct packed {
    logic                       frame_status;
    logic                       device_slot;
    logic [8*PAYLOAD_COUNT-1:0] payload;
  } entry_t;

endpackage

// ----- hw/rtl/brfr_regs.sv -----
module brfr_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output brfr_pkg::cfg_t    cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_byte           <= brfr_pkg::HEADER_RESET;
      cfg.first_device_address  <= brfr_pkg::FIRST_ADDR_RESET;
      cfg.second_device_address <= brfr_pkg::SECOND_ADDR_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        brfr_pkg::REG_HEADER:      cfg.header_byte           <= pwdata[7:0];
        brfr_pkg::REG_FIRST_ADDR:  cfg.first_device_address  <= pwdata[7:0];
        brfr_pkg::REG_SECOND_ADDR: cfg.second_device_address <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      brfr_pkg::REG_HEADER:      prdata = {24'd0, cfg.header_byte};
      brfr_pkg::REG_FIRST_ADDR:  prdata = {24'd0, cfg.first_device_address};
      brfr_pkg::REG_SECOND_ADDR: prdata = {24'd0, cfg.second_device_address};
      default:                   prdata = 32'd0;
    endcase
  end

endmodule

// ----- hw/rtl/brfr_front.sv -----
`include "battery_reply_frame_receiver_unit_defines.svh"

module brfr_front (
  input  logic              clk,
  input  logic              rst,
  input  brfr_pkg::cfg_t    cfg,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // rx_byte
  input  logic              s_tuser,   // action
  input  logic              q_full,
  output logic              q_push,
  output brfr_pkg::entry_t  q_entry
);

  localparam int PAY_W = 8 * brfr_pkg::PAYLOAD_COUNT;

  logic [brfr_pkg::POS_W-1:0] pos, pos_next, pos_cur;
  logic [7:0]                 sum, sum_next;
  logic [7:0]                 addr, addr_next;
  logic [PAY_W-1:0]           payload, payload_next;
  logic                       accept;
  logic                       addr_ok;
  logic [7:0]                 sum_add;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign pos_cur  = (pos > brfr_pkg::POS_LAST) ? brfr_pkg::POS_HEADER : pos;
  assign addr_ok  = (s_tdata == cfg.first_device_address) ||
                    (s_tdata == cfg.second_device_address);
  assign sum_add  = sum + s_tdata;

  always_comb begin
    pos_next     = pos;
    sum_next     = sum;
    addr_next    = addr;
    payload_next = payload;
    q_push       = 1'b0;
    q_entry.frame_status = (sum == s_tdata) ? brfr_pkg::STATUS_GOOD : brfr_pkg::STATUS_BAD;
    q_entry.device_slot  = (addr == cfg.first_device_address) ?
                           brfr_pkg::SLOT_FIRST : brfr_pkg::SLOT_SECOND;
    q_entry.payload      = payload;
    if (accept) begin
      if (s_tuser == brfr_pkg::ACTION_LINE_ERROR) begin
        pos_next = brfr_pkg::POS_HEADER;
        sum_next = 8'd0;
      end else if (pos_cur == brfr_pkg::POS_HEADER) begin
        // hunt for the header, dropping anything else
        if (s_tdata == cfg.header_byte) begin
          sum_next = s_tdata;
          pos_next = brfr_pkg::POS_ADDRESS;
        end else begin
          pos_next = brfr_pkg::POS_HEADER;
          sum_next = 8'd0;
        end
      end else if (pos_cur == brfr_pkg::POS_ADDRESS) begin
        if (addr_ok) begin
          addr_next = s_tdata;
          sum_next  = sum_add;
          pos_next  = pos_cur + 4'd1;
        end else begin
          pos_next = brfr_pkg::POS_HEADER;
          sum_next = 8'd0;
        end
      end else if (pos_cur < brfr_pkg::POS_LAST) begin
        if (pos_cur >= brfr_pkg::POS_PAYLOAD_FIRST) begin
          payload_next = {payload[PAY_W-9:0], s_tdata};
        end
        sum_next = sum_add;
        pos_next = pos_cur + 4'd1;
      end else begin
        // checksum word closes the frame
        q_push   = 1'b1;
        pos_next = brfr_pkg::POS_HEADER;
        sum_next = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= brfr_pkg::POS_HEADER;
      sum  <= 8'd0;
      addr <= 8'd0;
    end else begin
      pos  <= pos_next;
      sum  <= sum_next;
      addr <= addr_next;
    end
  end

  always_ff @(posedge clk) begin
    payload <= payload_next;
  end

  `BRFR_ASSERT_ALWAYS(a_pos_in_frame, clk, rst, pos <= brfr_pkg::POS_LAST)
  `BRFR_ASSERT_NEXT(a_line_error_restarts, clk, rst,
    accept && (s_tuser == brfr_pkg::ACTION_LINE_ERROR),
    (pos == brfr_pkg::POS_HEADER) && (sum == 8'd0))

endmodule

// ----- hw/rtl/brfr_fifo.sv -----
`include "battery_reply_frame_receiver_unit_defines.svh"

module brfr_fifo #(
  parameter int DEPTH = brfr_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  brfr_pkg::entry_t  wr_entry,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output brfr_pkg::entry_t  rd_entry
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  brfr_pkg::entry_t  store [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign rd_entry  = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  `BRFR_ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CNT_W'(DEPTH))
  `BRFR_ASSERT_SAME(a_no_push_full, clk, rst, push, !full)
  `BRFR_ASSERT_SAME(a_no_pop_empty, clk, rst, pop, not_empty)
  `BRFR_ASSERT_NEXT(a_count_up, clk, rst, push && !pop,
    count == $past(count) + CNT_W'(1))

endmodule

// ----- hw/rtl/brfr_back.sv -----
module brfr_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_not_empty,
  input  brfr_pkg::entry_t  q_entry,
  output logic              q_pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [63:0]       m_tdata,   // collected_voltage, accumulated_voltage,
                                       // pack_current, charge_level
  output logic [1:0]        m_tuser    // device_slot, frame_status
);

  logic [63:0] data_next;

  assign q_pop = q_not_empty && (!m_tvalid || m_tready);

  // Payload holds byte 4 on top; reorder into four big-endian fields, or zero for a bad frame.
  always_comb begin
    if (q_entry.frame_status == brfr_pkg::STATUS_GOOD) begin
      data_next = {q_entry.payload[15:0], q_entry.payload[31:16],
                   q_entry.payload[47:32], q_entry.payload[63:48]};
    end else begin
      data_next = 64'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (q_pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      m_tdata <= data_next;
      m_tuser <= {q_entry.device_slot, q_entry.frame_status};
    end
  end

endmodule

// ----- hw/rtl/battery_reply_frame_receiver_unit.sv -----
// A frame's checksum word pushes its result into the queue, and the registered output stage takes it from there.
// Throughput: one input word per cycle, held only when the two-entry result queue is full.
// Result words leave through a registered output stage that refills in the cycle it drains.
// Reset (rst, synchronous, active high) restarts frame assembly, empties the queue
// and output stage, and returns the three registers to 0xA5, 0x01 and 0x02.
module battery_reply_frame_receiver_unit #(
  parameter int QUEUE_DEPTH = brfr_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_byte
  input  logic        s_tuser,   // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // collected_voltage, accumulated_voltage,
                                 // pack_current, charge_level
  output logic [1:0]  m_tuser    // device_slot, frame_status
);

  brfr_pkg::cfg_t   cfg;
  brfr_pkg::entry_t push_entry, pop_entry;
  logic             q_push, q_pop, q_full, q_not_empty;

  brfr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  brfr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (push_entry)
  );

  brfr_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wr_entry  (push_entry),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rd_entry  (pop_entry)
  );

  brfr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_entry     (pop_entry),
    .q_pop       (q_pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

endmodule
